// ===== rtl/mie_pkg.sv =====
// shared constants for the modular inverse block
`default_nettype none

package mie_pkg;

  // width of the external data fields
  localparam int FIELD_W = 32;

  // default datapath width
  localparam int DEFAULT_WIDTH = 32;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOT_INV = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/mie_div_unit.sv =====
// shared shift-subtract divider step with shift-add quotient times coefficient
`default_nettype none

module mie_div_unit
  import mie_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  wire logic [WIDTH-1:0] rem,
  input  wire logic             dvd_msb,
  input  wire logic [WIDTH-1:0] divisor,
  input  wire logic [WIDTH-1:0] acc,
  input  wire logic [WIDTH-1:0] coef,
  output logic      [WIDTH-1:0] rem_next,
  output logic                  qbit,
  output logic      [WIDTH-1:0] acc_next
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;

  // bring down the next dividend bit and trial subtract
  assign shifted  = {rem, dvd_msb};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign qbit     = ~diff[WIDTH+1];
  assign rem_next = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

  // accumulate quotient times coefficient, msb first
  assign acc_next = {acc[WIDTH-2:0], 1'b0} + (qbit ? coef : {WIDTH{1'b0}});

endmodule

`default_nettype wire

// ===== rtl/modular_inverse_ext_euclid_top.sv =====
// modular inverse by the extended euclidean algorithm, top level
//
// Usage: write the modulus through cfg_we/cfg_wdata while the block is idle
// (reset value 1). Each transaction on the input channel (in_valid, in_stall,
// value) produces one transaction on the output channel (out_valid,
// out_stall, inverse, status). status 1 means the value has no inverse
// (zero, a multiple of the modulus, a common factor, or modulus zero) and
// inverse is then 0. A modulus of one gives inverse 1.
// Only the low WIDTH bits of modulus and value are used.
// Timing: one shared bit-serial divider does all the work, one quotient bit
// per cycle. The value is first reduced modulo the modulus, then each Euclid
// step runs one further division, and the result is then moved to the output
// register.
// in_stall stays high while an item is in progress; one item at a time.
// The result sits in an output register, so a new item is accepted while a
// stalled result waits; a further result waits until the register frees.
// Reset (rst, synchronous) drops any item in progress and any pending result.
`default_nettype none

module modular_inverse_ext_euclid_top
  import mie_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [FIELD_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FIELD_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [FIELD_W-1:0] inverse,
  output logic                    status
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state;
  logic [FIELD_W-1:0] modulus;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] r0;
  logic [WIDTH-1:0] r1;
  logic [WIDTH-1:0] u0;
  logic [WIDTH-1:0] u1;
  logic             neg;
  logic             reduce;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] div_d;
  logic [WIDTH-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] res_inv;
  logic             res_status;

  logic [WIDTH-1:0] m_in;
  logic [WIDTH-1:0] v_in;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] acc_next;
  logic             qbit;
  logic             in_acc;
  logic             out_free;

  assign m_in     = WIDTH'(modulus);
  assign v_in     = WIDTH'(value);
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= FIELD_W'(1);
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // shared divider step
  mie_div_unit #(
    .WIDTH (WIDTH)
  ) u_div (
    .rem      (rem),
    .dvd_msb  (dvd[WIDTH-1]),
    .divisor  (div_d),
    .acc      (acc),
    .coef     (u1),
    .rem_next (rem_next),
    .qbit     (qbit),
    .acc_next (acc_next)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            m      <= m_in;
            r0     <= m_in;
            u0     <= '0;
            u1     <= WIDTH'(1);
            neg    <= 1'b0;
            reduce <= 1'b1;
            dvd    <= v_in;
            div_d  <= m_in;
            rem    <= '0;
            acc    <= '0;
            cnt    <= '0;
            if (m_in == WIDTH'(1)) begin
              res_inv    <= WIDTH'(1);
              res_status <= STATUS_OK;
              state      <= ST_FIN;
            end else if (m_in == '0) begin
              res_inv    <= '0;
              res_status <= STATUS_NOT_INV;
              state      <= ST_FIN;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          acc <= acc_next;
          dvd <= {dvd[WIDTH-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          // take remainder, and for a Euclid step also the coefficient
          r1 <= rem;
          if (!reduce) begin
            r0  <= r1;
            u0  <= u1;
            u1  <= acc + u0;
            neg <= !neg;
          end
          reduce <= 1'b0;
          state  <= ST_CHECK;
        end
        ST_CHECK: begin
          if (r1 == '0) begin
            res_inv    <= '0;
            res_status <= STATUS_NOT_INV;
            state      <= ST_FIN;
          end else if (r1 == WIDTH'(1)) begin
            res_inv    <= neg ? (m - u1) : u1;
            res_status <= STATUS_OK;
            state      <= ST_FIN;
          end else begin
            dvd   <= r0;
            div_d <= r1;
            rem   <= '0;
            acc   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      inverse <= FIELD_W'(res_inv);
      status  <= res_status;
    end
  end

  // checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_NOT_INV |-> inverse == '0)
    else $error("not invertible result carries a nonzero inverse");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after a transaction");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_d != '0)
    else $error("divider running with a zero divisor");

  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free |=> out_valid && state == ST_IDLE)
    else $error("finished result not moved to the output register");

endmodule

`default_nettype wire
